@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLKRST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/rc5_pkg.sv @@
package rc5_pkg;

    localparam int WORD_W      = 32;
    localparam int ROT_W       = 5;
    localparam int KEY_INDEX_W = 5;
    localparam int RESET_WORDS = 26;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_ENCRYPT = 1'b1
    } t_kind;

    localparam t_word RESET_TABLE [RESET_WORDS] = '{
        32'h9BBBD8C8, 32'h1A37F7FB, 32'h46F8E8C5, 32'h460C6085, 32'h70F83B8A,
        32'h284B8303, 32'h513E1454, 32'hF621ED22, 32'h3125065D, 32'h11A83A5D,
        32'hD427686B, 32'h713AD82D, 32'h4B792F99, 32'h2799A4DD, 32'hA7901C49,
        32'hDEDE871A, 32'h36C03196, 32'hA7EFC249, 32'h61A78BB8, 32'h3B0A1D2B,
        32'h4DBFCA76, 32'hAE162167, 32'h30D76B0A, 32'h43192304, 32'hF6CC1431,
        32'h65046380
    };

    function automatic t_word reset_key(input int idx);
        t_word val;
        val = '0;
        if (idx < RESET_WORDS) begin
            val = RESET_TABLE[idx];
        end
        return val;
    endfunction

    // rotate by zero returns the word unchanged
    function automatic t_word rotl(input t_word w, input logic [ROT_W-1:0] amt);
        logic [2*WORD_W-1:0] dbl;
        dbl = {w, w} << amt;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

@@ hdl/rc5_key_table.sv @@
module rc5_key_table #(
    parameter int ROUNDS = 12
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_we,
    input  logic [rc5_pkg::KEY_INDEX_W-1:0]          i_key_index,
    input  rc5_pkg::t_word                           i_key_word,
    output rc5_pkg::t_word [2*ROUNDS+1:0]            o_keys
);
    import rc5_pkg::*;

    localparam int NUM_KEYS   = 2 * ROUNDS + 2;
    localparam int MAX_STORED = 1 << KEY_INDEX_W;
    localparam int NUM_STORED = (NUM_KEYS < MAX_STORED) ? NUM_KEYS : MAX_STORED;

    for (genvar j = 0; j < NUM_KEYS; j++) begin : g_key
        if (j < NUM_STORED) begin : g_reg
            t_word r_key;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_key <= reset_key(j);
                end else if (i_we && (i_key_index == KEY_INDEX_W'(j))) begin
                    r_key <= i_key_word;
                end
            end

            assign o_keys[j] = r_key;
        end else begin : g_const
            // beyond the reach of the load index: reset value stays
            assign o_keys[j] = reset_key(j);
        end
    end

endmodule

@@ hdl/rc5_half_round.sv @@
module rc5_half_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rc5_pkg::t_word i_x,
    input  rc5_pkg::t_word i_y,
    input  rc5_pkg::t_word i_key,
    output logic           o_valid,
    output rc5_pkg::t_word o_x,
    output rc5_pkg::t_word o_y
);
    import rc5_pkg::*;

    logic  r_valid;
    t_word r_x;
    t_word r_y;
    t_word n_x;

    assign n_x = rotl(i_x ^ i_y, i_y[ROT_W-1:0]) + i_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= i_y;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

@@ hdl/rc5_block_encrypt.sv @@
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_kind, i_key_index, i_key_word, i_plain_block
// output    out        o_valid / i_stall  o_cipher_block
//
// one word per cycle while o_stall is low; an encrypt word passes through the key add stage,
// then one stage per half round
// a load word writes the key table when it is accepted and gives no output word
// a load word waits while an encrypt word is still in the key add stage or any round stage but the last
// reset restores the key table; an output stall while o_valid is high freezes the whole pipeline
`include "assert_macros.svh"

module rc5_block_encrypt #(
    parameter int ROUNDS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic [rc5_pkg::KEY_INDEX_W-1:0]   i_key_index,
    input  logic [31:0]                       i_key_word,
    input  logic [63:0]                       i_plain_block,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [63:0]                       o_cipher_block
);
    import rc5_pkg::*;

    localparam int NUM_KEYS   = 2 * ROUNDS + 2;
    localparam int NUM_STAGES = 2 * ROUNDS;

    t_word [NUM_KEYS-1:0] w_keys;
    logic  [NUM_STAGES:0] v;
    t_word                a [NUM_STAGES+1];
    t_word                b [NUM_STAGES+1];

    logic  en;
    logic  busy;
    logic  is_load;
    logic  load_acc;
    logic  r_v0;
    t_word r_a0;
    t_word r_b0;

    assign en       = !(o_valid && i_stall);
    assign busy     = |v[NUM_STAGES-1:0];
    assign is_load  = (t_kind'(i_kind) == KIND_LOAD);
    assign o_stall  = !en || (is_load && busy);
    assign load_acc = i_valid && !o_stall && is_load;

    rc5_key_table #(
        .ROUNDS (ROUNDS)
    ) u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (load_acc),
        .i_key_index (i_key_index),
        .i_key_word  (i_key_word),
        .o_keys      (w_keys)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid && (t_kind'(i_kind) == KIND_ENCRYPT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0 <= i_plain_block[63:32] + w_keys[0];
            r_b0 <= i_plain_block[31:0] + w_keys[1];
        end
    end

    assign v[0] = r_v0;
    assign a[0] = r_a0;
    assign b[0] = r_b0;

    for (genvar j = 1; j <= NUM_STAGES; j++) begin : g_stage
        if ((j % 2) == 1) begin : g_a
            rc5_half_round u_half (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (v[j-1]),
                .i_x     (a[j-1]),
                .i_y     (b[j-1]),
                .i_key   (w_keys[j+1]),
                .o_valid (v[j]),
                .o_x     (a[j]),
                .o_y     (b[j])
            );
        end else begin : g_b
            rc5_half_round u_half (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (v[j-1]),
                .i_x     (b[j-1]),
                .i_y     (a[j-1]),
                .i_key   (w_keys[j+1]),
                .o_valid (v[j]),
                .o_x     (b[j]),
                .o_y     (a[j])
            );
        end
    end

    assign o_valid        = v[NUM_STAGES];
    assign o_cipher_block = {a[NUM_STAGES], b[NUM_STAGES]};

    `ASSERT_CLKRST(a_load_no_inflight, load_acc |-> !busy, "key load while encrypt in flight")
    `ASSERT_CLKRST(a_hold_freezes, (o_valid && i_stall) |=> $stable(v), "pipeline moved under stall")
    `ASSERT_CLKRST(a_enc_enters, (i_valid && !o_stall && !is_load) |=> r_v0, "encrypt word lost")
    `ASSERT_CLK(a_reset_empty, !i_rst_n |=> (v == '0), "pipeline not empty after reset")

endmodule
